// ===== hw/rtl/pqr_pkg.sv =====
// ============================================================================
// pqr_pkg
// Shared types, constants and helpers for the pose quaternion retraction.
// ============================================================================
package pqr_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int TRIG_ITER_DEF = 24;

    localparam logic OP_ROT   = 1'b0;
    localparam logic OP_TRANS = 1'b1;

    // Q30 angle constants, 36-bit signed
    localparam logic signed [35:0] TWO_PI_Q30   = 36'sd6746518852;
    localparam logic signed [35:0] PI_Q30       = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30  = 36'sd1686629713;
    localparam logic signed [35:0] CORDIC_K_Q30 = 36'sd652032874;
    localparam logic signed [35:0] Q30_ONE      = 36'sd1073741824;
    localparam logic signed [35:0] Q30_NEG_ONE  = -36'sd1073741824;

    typedef struct packed {
        logic               op;
        logic signed [31:0] v0;
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        logic signed [31:0] v3;
        logic signed [31:0] d0;
        logic signed [31:0] d1;
        logic signed [31:0] d2;
    } req_t;

    typedef struct packed {
        logic signed [31:0] r0;
        logic signed [31:0] r1;
        logic signed [31:0] r2;
        logic signed [31:0] r3;
        logic               saturated;
    } rsp_t;

    // CORDIC arctangent table, Q30
    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] a;
        begin
            unique case (i)
                0:  a = 30'd843314857;
                1:  a = 30'd497837829;
                2:  a = 30'd263043836;
                3:  a = 30'd133525158;
                4:  a = 30'd67021686;
                5:  a = 30'd33543515;
                6:  a = 30'd16775850;
                7:  a = 30'd8388437;
                8:  a = 30'd4194282;
                9:  a = 30'd2097149;
                10: a = 30'd1048575;
                11: a = 30'd524287;
                12: a = 30'd262143;
                13: a = 30'd131071;
                14: a = 30'd65535;
                15: a = 30'd32767;
                16: a = 30'd16383;
                17: a = 30'd8191;
                18: a = 30'd4095;
                19: a = 30'd2047;
                20: a = 30'd1023;
                21: a = 30'd511;
                22: a = 30'd255;
                23: a = 30'd127;
                24: a = 30'd63;
                25: a = 30'd31;
                26: a = 30'd15;
                27: a = 30'd8;
                28: a = 30'd4;
                29: a = 30'd2;
                30: a = 30'd1;
                default: a = 30'd0;
            endcase
            return a;
        end
    endfunction

    // Saturate to 32-bit signed; bit 32 of the result flags a clamp.
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        begin
            if (v > 64'sd2147483647)
                r = {1'b1, 32'h7FFF_FFFF};
            else if (v < -64'sd2147483648)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, v[31:0]};
            return r;
        end
    endfunction

    // Magnitude of a 32-bit signed value, exact for the most negative code.
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

// ===== hw/rtl/pose_quaternion_retraction.sv =====
// ============================================================================
// pose_quaternion_retraction
// Pipelined increment step for a pose held as quaternion plus translation.
// ============================================================================
// Takes one request per cycle while no finished result is stalled, and returns
// one result per request, in order. The pipeline is built from the
// bit-per-stage square root (32 stages), the angle reduction modulo 2*pi
// (MOD_STEPS = 30 - FRAC_BITS compare-subtract steps, one per stage), one
// CORDIC step per stage and the three bit-per-stage dividers that scale the
// rotation vector (32 stages).
// The whole pipeline freezes while a finished result is stalled; req_stall
// is high exactly when rsp_valid is high and rsp_stall is high.
// Rotation (op 0): full-angle delta quaternion (cos n, sin n / n * d) times
// the input quaternion, Q30 trig, rounded and saturated back to Q8.24.
// Translation (op 1): saturating add, r3 forced to zero.
module pose_quaternion_retraction
    import pqr_pkg::*;
#(
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int ANG_W     = 62 - FRAC_BITS;   // width of n in Q30
    localparam int SHIFT     = 30 - FRAC_BITS;
    localparam int MOD_STEPS = ANG_W - 32;       // compare-subtract steps
    localparam int ITERS     = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
    localparam int ZW        = 36;               // angle width
    localparam int XW        = 34;               // CORDIC x/y width

    typedef struct packed {
        req_t        item;
        logic [31:0] n;
    } ctx_t;

    typedef struct packed {
        req_t               item;
        logic [31:0]        n;
        logic signed [31:0] a0;
        logic [2:0]         sgn;
    } rot_t;

    // global advance: the pipeline moves unless the output holds a stalled result
    logic adv;
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    assign adv       = ~rsp_valid_reg | ~rsp_stall;
    assign req_stall = ~adv;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Squares of the increment, then their sum
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    req_t        s1_item_reg;
    logic [63:0] s1_sq_reg [3];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            s1_item_reg  <= req;
            s1_sq_reg[0] <= 64'(mag32(req.d0)) * 64'(mag32(req.d0));
            s1_sq_reg[1] <= 64'(mag32(req.d1)) * 64'(mag32(req.d1));
            s1_sq_reg[2] <= 64'(mag32(req.d2)) * 64'(mag32(req.d2));
        end
    end

    // square root pipeline, index 0 loaded with the sum of squares
    logic        sq_valid_reg [0:32];
    req_t        sq_item_reg  [0:32];
    logic [63:0] sq_x_reg     [0:32];
    logic [33:0] sq_rem_reg   [0:32];
    logic [31:0] sq_root_reg  [0:32];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (adv)
            sq_valid_reg[0] <= s1_valid_reg;
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            sq_item_reg[0] <= s1_item_reg;
            sq_x_reg[0]    <= s1_sq_reg[0] + s1_sq_reg[1] + s1_sq_reg[2];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < 32; j++) begin : g_sqrt
        localparam int B = 2 * (31 - j);
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic        take;

        always_comb begin
            rem_sh = {sq_rem_reg[j], sq_x_reg[j][B+1:B]};
            trial  = {2'b00, sq_root_reg[j], 2'b01};
            take   = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
                sq_valid_reg[j+1] <= 1'b0;
            else if (adv)
                sq_valid_reg[j+1] <= sq_valid_reg[j];
        end

        always_ff @(posedge clk) begin
            if (adv)
            begin
                sq_item_reg[j+1] <= sq_item_reg[j];
                sq_x_reg[j+1]    <= sq_x_reg[j];
                sq_rem_reg[j+1]  <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
                sq_root_reg[j+1] <= {sq_root_reg[j][30:0], take};
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle in Q30, reduced modulo 2*pi
    // ------------------------------------------------------------------
    logic             md_valid_reg [0:MOD_STEPS];
    ctx_t             md_ctx_reg   [0:MOD_STEPS];
    logic [ANG_W-1:0] md_rem_reg   [0:MOD_STEPS];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            md_valid_reg[0] <= 1'b0;
        else if (adv)
            md_valid_reg[0] <= sq_valid_reg[32];
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            md_ctx_reg[0] <= '{item: sq_item_reg[32], n: sq_root_reg[32]};
            md_rem_reg[0] <= ANG_W'(sq_root_reg[32]) << SHIFT;
        end
    end

    for (genvar m = 0; m < MOD_STEPS; m++) begin : g_mod
        localparam int K = MOD_STEPS - 1 - m;
        localparam logic [ANG_W-1:0] CK = ANG_W'(TWO_PI_Q30) << K;

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
                md_valid_reg[m+1] <= 1'b0;
            else if (adv)
                md_valid_reg[m+1] <= md_valid_reg[m];
        end

        always_ff @(posedge clk) begin
            if (adv)
            begin
                md_ctx_reg[m+1] <= md_ctx_reg[m];
                md_rem_reg[m+1] <= (md_rem_reg[m] >= CK) ? (md_rem_reg[m] - CK)
                                                         : md_rem_reg[m];
            end
        end
    end

    // ------------------------------------------------------------------
    // Fold into [-pi/2, pi/2], then CORDIC rotation, one step per stage
    // ------------------------------------------------------------------
    logic                 cd_valid_reg [0:ITERS];
    ctx_t                 cd_ctx_reg   [0:ITERS];
    logic                 cd_neg_reg   [0:ITERS];
    logic signed [ZW-1:0] cd_z_reg     [0:ITERS];
    logic signed [XW-1:0] cd_x_reg     [0:ITERS];
    logic signed [XW-1:0] cd_y_reg     [0:ITERS];

    logic signed [ZW-1:0] fold_wrap;
    logic signed [ZW-1:0] fold_z;
    logic                 fold_neg;

    always_comb begin
        fold_wrap = $signed(ZW'(md_rem_reg[MOD_STEPS]));
        if (fold_wrap > PI_Q30)
            fold_wrap = fold_wrap - TWO_PI_Q30;
        fold_z   = fold_wrap;
        fold_neg = 1'b0;
        if (fold_wrap > HALF_PI_Q30)
        begin
            fold_z   = fold_wrap - PI_Q30;
            fold_neg = 1'b1;
        end
        else if (fold_wrap < -HALF_PI_Q30)
        begin
            fold_z   = fold_wrap + PI_Q30;
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            cd_valid_reg[0] <= 1'b0;
        else if (adv)
            cd_valid_reg[0] <= md_valid_reg[MOD_STEPS];
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            cd_ctx_reg[0] <= md_ctx_reg[MOD_STEPS];
            cd_neg_reg[0] <= fold_neg;
            cd_z_reg[0]   <= fold_z;
            cd_x_reg[0]   <= XW'(CORDIC_K_Q30);
            cd_y_reg[0]   <= '0;
        end
    end

    for (genvar i = 0; i < ITERS; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] AT = ZW'(atan_q30(i));
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;

        assign dx = cd_y_reg[i] >>> i;
        assign dy = cd_x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
                cd_valid_reg[i+1] <= 1'b0;
            else if (adv)
                cd_valid_reg[i+1] <= cd_valid_reg[i];
        end

        always_ff @(posedge clk) begin
            if (adv)
            begin
                cd_ctx_reg[i+1] <= cd_ctx_reg[i];
                cd_neg_reg[i+1] <= cd_neg_reg[i];
                if (!cd_z_reg[i][ZW-1])
                begin
                    cd_x_reg[i+1] <= cd_x_reg[i] - dx;
                    cd_y_reg[i+1] <= cd_y_reg[i] + dy;
                    cd_z_reg[i+1] <= cd_z_reg[i] - AT;
                end
                else
                begin
                    cd_x_reg[i+1] <= cd_x_reg[i] + dx;
                    cd_y_reg[i+1] <= cd_y_reg[i] - dy;
                    cd_z_reg[i+1] <= cd_z_reg[i] + AT;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // cos clamp, |sin| and signs; then |sin|*|d| + n/2 per axis
    // ------------------------------------------------------------------
    logic signed [XW-1:0] p1_c;
    logic signed [XW-1:0] p1_s;
    logic signed [31:0]   p1_a0;
    logic [2:0]           p1_sgn;

    always_comb begin
        p1_c = cd_neg_reg[ITERS] ? -cd_x_reg[ITERS] : cd_x_reg[ITERS];
        p1_s = cd_neg_reg[ITERS] ? -cd_y_reg[ITERS] : cd_y_reg[ITERS];
        if (p1_c > Q30_ONE)
            p1_a0 = 32'(Q30_ONE);
        else if (p1_c < Q30_NEG_ONE)
            p1_a0 = 32'(Q30_NEG_ONE);
        else
            p1_a0 = 32'(p1_c);
        p1_sgn = {p1_s[XW-1] ^ cd_ctx_reg[ITERS].item.d2[31],
                  p1_s[XW-1] ^ cd_ctx_reg[ITERS].item.d1[31],
                  p1_s[XW-1] ^ cd_ctx_reg[ITERS].item.d0[31]};
    end

    logic        p1_valid_reg;
    rot_t        p1_rot_reg;
    logic [31:0] p1_smag_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (adv)
            p1_valid_reg <= cd_valid_reg[ITERS];
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            p1_rot_reg  <= '{item: cd_ctx_reg[ITERS].item, n: cd_ctx_reg[ITERS].n,
                             a0: p1_a0, sgn: p1_sgn};
            p1_smag_reg <= 32'(p1_s[XW-1] ? -p1_s : p1_s);
        end
    end

    // divider pipeline: three lanes, one quotient bit per stage
    logic        dv_valid_reg [0:32];
    rot_t        dv_rot_reg   [0:32];
    logic [63:0] dv_num_reg   [0:32][3];
    logic [31:0] dv_rem_reg   [0:32][3];
    logic [31:0] dv_q_reg     [0:32][3];

    logic [31:0] p2_dmag [3];
    logic [63:0] p2_num  [3];

    always_comb begin
        p2_dmag[0] = mag32(p1_rot_reg.item.d0);
        p2_dmag[1] = mag32(p1_rot_reg.item.d1);
        p2_dmag[2] = mag32(p1_rot_reg.item.d2);
        for (int k = 0; k < 3; k++)
            p2_num[k] = 64'(p1_smag_reg) * 64'(p2_dmag[k]) + 64'(p1_rot_reg.n >> 1);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= p1_valid_reg;
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            dv_rot_reg[0] <= p1_rot_reg;
            for (int k = 0; k < 3; k++)
            begin
                dv_num_reg[0][k] <= p2_num[k];
                dv_rem_reg[0][k] <= p2_num[k][63:32];
                dv_q_reg[0][k]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < 32; j++) begin : g_div
        localparam int BIT = 31 - j;
        logic [32:0] r2   [3];
        logic        take [3];

        always_comb begin
            for (int k = 0; k < 3; k++)
            begin
                r2[k]   = {dv_rem_reg[j][k], dv_num_reg[j][k][BIT]};
                take[k] = (r2[k] >= {1'b0, dv_rot_reg[j].n});
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
                dv_valid_reg[j+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[j+1] <= dv_valid_reg[j];
        end

        always_ff @(posedge clk) begin
            if (adv)
            begin
                dv_rot_reg[j+1] <= dv_rot_reg[j];
                for (int k = 0; k < 3; k++)
                begin
                    dv_num_reg[j+1][k] <= dv_num_reg[j][k];
                    dv_rem_reg[j+1][k] <= take[k] ? 32'(r2[k] - {1'b0, dv_rot_reg[j].n})
                                                  : r2[k][31:0];
                    dv_q_reg[j+1][k]   <= {dv_q_reg[j][k][30:0], take[k]};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Signed, clamped delta quaternion; 16 products; sums and saturation
    // ------------------------------------------------------------------
    logic signed [32:0] qd_s [3];
    logic signed [31:0] qd_a [3];

    always_comb begin
        for (int k = 0; k < 3; k++)
        begin
            qd_s[k] = dv_rot_reg[32].sgn[k] ? -$signed({1'b0, dv_q_reg[32][k]})
                                            :  $signed({1'b0, dv_q_reg[32][k]});
            if (qd_s[k] > Q30_ONE)
                qd_a[k] = 32'(Q30_ONE);
            else if (qd_s[k] < Q30_NEG_ONE)
                qd_a[k] = 32'(Q30_NEG_ONE);
            else
                qd_a[k] = 32'(qd_s[k]);
        end
    end

    logic               qa_valid_reg;
    rot_t               qa_rot_reg;
    logic signed [31:0] qa_a_reg [4];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            qa_valid_reg <= 1'b0;
        else if (adv)
            qa_valid_reg <= dv_valid_reg[32];
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            qa_rot_reg  <= dv_rot_reg[32];
            qa_a_reg[0] <= dv_rot_reg[32].a0;
            qa_a_reg[1] <= qd_a[0];
            qa_a_reg[2] <= qd_a[1];
            qa_a_reg[3] <= qd_a[2];
        end
    end

    logic signed [31:0] mv [4];
    logic signed [63:0] mp [4][4];

    always_comb begin
        mv[0] = qa_rot_reg.item.v0;
        mv[1] = qa_rot_reg.item.v1;
        mv[2] = qa_rot_reg.item.v2;
        mv[3] = qa_rot_reg.item.v3;
        for (int a = 0; a < 4; a++)
            for (int v = 0; v < 4; v++)
                mp[a][v] = 64'(qa_a_reg[a]) * 64'(mv[v]);
    end

    logic               pm_valid_reg;
    ctx_t               pm_ctx_reg;
    logic signed [61:0] pm_p_reg [4][4];   // a_j * v_k >>> 2

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            pm_valid_reg <= 1'b0;
        else if (adv)
            pm_valid_reg <= qa_valid_reg;
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            pm_ctx_reg <= '{item: qa_rot_reg.item, n: qa_rot_reg.n};
            for (int a = 0; a < 4; a++)
                for (int v = 0; v < 4; v++)
                    pm_p_reg[a][v] <= 62'(mp[a][v] >>> 2);
        end
    end

    // Hamilton product qd * q, with round-half-up shift back to Q8.24
    logic signed [63:0] hs [4];
    logic signed [63:0] hf [4];
    logic [32:0]        hsat [4];
    logic [32:0]        tsat [3];
    rsp_t               rsp_next;
    req_t               oit;

    always_comb begin
        oit   = pm_ctx_reg.item;
        hs[0] = 64'(pm_p_reg[0][0]) - 64'(pm_p_reg[1][1])
              - 64'(pm_p_reg[2][2]) - 64'(pm_p_reg[3][3]);
        hs[1] = 64'(pm_p_reg[0][1]) + 64'(pm_p_reg[1][0])
              + 64'(pm_p_reg[2][3]) - 64'(pm_p_reg[3][2]);
        hs[2] = 64'(pm_p_reg[0][2]) - 64'(pm_p_reg[1][3])
              + 64'(pm_p_reg[2][0]) + 64'(pm_p_reg[3][1]);
        hs[3] = 64'(pm_p_reg[0][3]) + 64'(pm_p_reg[1][2])
              - 64'(pm_p_reg[2][1]) + 64'(pm_p_reg[3][0]);
        for (int k = 0; k < 4; k++)
        begin
            hf[k]   = (hs[k] + 64'sd134217728) >>> 28;
            hsat[k] = sat32(hf[k]);
        end
        tsat[0] = sat32(64'(oit.v0) + 64'(oit.d0));
        tsat[1] = sat32(64'(oit.v1) + 64'(oit.d1));
        tsat[2] = sat32(64'(oit.v2) + 64'(oit.d2));

        if (oit.op == OP_TRANS)
        begin
            rsp_next.r0        = tsat[0][31:0];
            rsp_next.r1        = tsat[1][31:0];
            rsp_next.r2        = tsat[2][31:0];
            rsp_next.r3        = '0;
            rsp_next.saturated = tsat[0][32] | tsat[1][32] | tsat[2][32];
        end
        else if (pm_ctx_reg.n == '0)
        begin
            // zero increment: quaternion passes through
            rsp_next.r0        = oit.v0;
            rsp_next.r1        = oit.v1;
            rsp_next.r2        = oit.v2;
            rsp_next.r3        = oit.v3;
            rsp_next.saturated = 1'b0;
        end
        else
        begin
            rsp_next.r0        = hsat[0][31:0];
            rsp_next.r1        = hsat[1][31:0];
            rsp_next.r2        = hsat[2][31:0];
            rsp_next.r3        = hsat[3][31:0];
            rsp_next.saturated = hsat[0][32] | hsat[1][32] | hsat[2][32] | hsat[3][32];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= pm_valid_reg;
    end

    always_ff @(posedge clk) begin
        if (adv)
            rsp_reg <= rsp_next;
    end

endmodule

// ===== hw/rtl/pqr_checker.sv =====
// ============================================================================
// pqr_props
// Port-level checks for the pose quaternion retraction pipeline.
// ============================================================================
module pqr_props
    import pqr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // request side stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without output backpressure");

    // a free output never stalls requests
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid || !rsp_stall |-> !req_stall)
        else $error("request stalled while output is free");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !rsp_valid)
        else $error("result valid right after reset");

endmodule

bind pose_quaternion_retraction pqr_props u_pqr_props (.*);

// ===== tb/pqr_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pqr_checker
// Watches both channels, predicts each result from its request and compares.
// ============================================================================
module pqr_checker
    import pqr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_stall,
    input  req_t       req,
    input  logic       rsp_valid,
    input  logic       rsp_stall,
    input  rsp_t       rsp,
    output int         fail_count,
    output int         pending_count
);

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int TRIG = TRIG_ITER_DEF;
    localparam longint PI_L      = 64'sd3373259426;
    localparam longint HALF_PI_L = 64'sd1686629713;
    localparam longint TWO_PI_L  = 64'sd6746518852;
    localparam longint ONE_L     = 64'sd1073741824;

    rsp_t pose_q[$];

    longint unsigned arctan_tab [32] = '{
        843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 8, 4, 2, 1, 0};

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clip32(longint v, inout logic flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint unit_clip(longint v);
        if (v > ONE_L)
            return ONE_L;
        if (v < -ONE_L)
            return -ONE_L;
        return v;
    endfunction

    function automatic longint term(longint a, longint b);
        return asr(a * b, 2);
    endfunction

    function automatic logic [31:0] fin(longint sum, inout logic flag);
        return clip32(asr(sum + (64'sd1 << 27), 28), flag);
    endfunction

    function automatic rsp_t retract(req_t r);
        rsp_t o;
        logic flag;
        longint v [4];
        longint d [3];
        longint a [4];
        longint unsigned sumsq, n, m, q;
        longint z, x, y, dx, dy, c, s, qs;
        logic neg;
        flag = 1'b0;
        v[0] = r.v0; v[1] = r.v1; v[2] = r.v2; v[3] = r.v3;
        d[0] = r.d0; d[1] = r.d1; d[2] = r.d2;
        if (r.op == OP_TRANS)
        begin
            o.r0 = clip32(v[0] + d[0], flag);
            o.r1 = clip32(v[1] + d[1], flag);
            o.r2 = clip32(v[2] + d[2], flag);
            o.r3 = '0;
        end
        else
        begin
            sumsq = 0;
            for (int k = 0; k < 3; k++)
            begin
                m = (d[k] < 0) ? -d[k] : d[k];
                sumsq += m * m;
            end
            n = root64(sumsq);
            if (n == 0)
            begin
                o.r0 = r.v0; o.r1 = r.v1; o.r2 = r.v2; o.r3 = r.v3;
            end
            else
            begin
                z = longint'((n << (30 - FRAC)) % TWO_PI_L);
                x = 652032874;
                y = 0;
                neg = 1'b0;
                if (z > PI_L)
                    z -= TWO_PI_L;
                if (z > HALF_PI_L)
                begin
                    z -= PI_L;
                    neg = 1'b1;
                end
                else if (z < -HALF_PI_L)
                begin
                    z += PI_L;
                    neg = 1'b1;
                end
                for (int i = 0; i < TRIG && i < 32; i++)
                begin
                    dx = asr(y, i);
                    dy = asr(x, i);
                    if (z >= 0)
                    begin
                        x -= dx; y += dy; z -= longint'(arctan_tab[i]);
                    end
                    else
                    begin
                        x += dx; y -= dy; z += longint'(arctan_tab[i]);
                    end
                end
                c = neg ? -x : x;
                s = neg ? -y : y;
                a[0] = unit_clip(c);
                for (int k = 0; k < 3; k++)
                begin
                    m = (d[k] < 0) ? -d[k] : d[k];
                    q = ((s < 0 ? -s : s) * m + n / 2) / n;
                    qs = longint'(q);
                    if ((s < 0) != (d[k] < 0))
                        qs = -qs;
                    a[1 + k] = unit_clip(qs);
                end
                o.r0 = fin(term(a[0], v[0]) - term(a[1], v[1])
                           - term(a[2], v[2]) - term(a[3], v[3]), flag);
                o.r1 = fin(term(a[0], v[1]) + term(a[1], v[0])
                           + term(a[2], v[3]) - term(a[3], v[2]), flag);
                o.r2 = fin(term(a[0], v[2]) - term(a[1], v[3])
                           + term(a[2], v[0]) + term(a[3], v[1]), flag);
                o.r3 = fin(term(a[0], v[3]) + term(a[1], v[2])
                           - term(a[2], v[1]) + term(a[3], v[0]), flag);
            end
        end
        o.saturated = flag;
        return o;
    endfunction

    initial
    begin
        fail_count = 0;
        pending_count = 0;
    end

    always @(posedge clk)
    begin
        rsp_t exp_pose;
        if (rst_n && req_valid && !req_stall)
            pose_q.push_back(retract(req));
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pose_q.size() == 0)
            begin
                $error("result with no request pending");
                fail_count++;
            end
            else
            begin
                exp_pose = pose_q.pop_front();
                if (rsp.r0 !== exp_pose.r0)
                begin
                    $error("r0 exp %0d got %0d", exp_pose.r0, rsp.r0);
                    fail_count++;
                end
                if (rsp.r1 !== exp_pose.r1)
                begin
                    $error("r1 exp %0d got %0d", exp_pose.r1, rsp.r1);
                    fail_count++;
                end
                if (rsp.r2 !== exp_pose.r2)
                begin
                    $error("r2 exp %0d got %0d", exp_pose.r2, rsp.r2);
                    fail_count++;
                end
                if (rsp.r3 !== exp_pose.r3)
                begin
                    $error("r3 exp %0d got %0d", exp_pose.r3, rsp.r3);
                    fail_count++;
                end
                if (rsp.saturated !== exp_pose.saturated)
                begin
                    $error("saturated exp %0b got %0b", exp_pose.saturated,
                           rsp.saturated);
                    fail_count++;
                end
            end
        end
        pending_count = pose_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stimulus and verdict for the pose quaternion retraction.
// ============================================================================
// Directed corner requests, then random rotation and translation requests
// under several idle/stall phases, including a long receiver hold-off and a
// full drain. The checker predicts every result and counts mismatches.
module tb_top;
    import pqr_pkg::*;

    localparam int LATENCY = 104;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    int   fail_count;
    int   pending_count;
    int   idle_pct;     // sender idle chance
    int   stall_pct;    // receiver stall chance
    logic hold_off;     // long receiver hold-off

    pose_quaternion_retraction dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    pqr_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver stall: random per cycle, forced high during a hold-off
    always @(posedge clk)
    begin
        rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // rough Q8.24 value: mix of full range, small angles and corners
    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(8) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(33554432)) - 16777216);
            3: return 32'($signed($urandom_range(2000)) - 1000);
            default: return 32'($signed($urandom_range(134217728)) - 67108864);
        endcase
    endfunction

    // one request: maybe idle, drive, hold until the accepting edge
    task automatic send_pose(logic op, logic [31:0] a0, logic [31:0] a1,
                             logic [31:0] a2, logic [31:0] a3, logic [31:0] b0,
                             logic [31:0] b1, logic [31:0] b2);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{op, a0, a1, a2, a3, b0, b1, b2};
        @(posedge clk iff !req_stall);
    endtask

    task automatic send_random();
        logic [31:0] b0, b1, b2;
        b0 = rand_word();
        b1 = rand_word();
        b2 = rand_word();
        if ($urandom_range(9) == 0)
        begin
            b0 = '0; b1 = '0; b2 = '0;
        end
        send_pose(1'($urandom_range(1)), rand_word(), rand_word(), rand_word(),
                  rand_word(), b0, b1, b2);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // hold-off runs in its own process, counted in cycles
    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (400) @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero increment, identity, extremes, saturation, wrap
        send_pose(OP_ROT, 32'h0100_0000, 0, 0, 0, 0, 0, 0);
        send_pose(OP_ROT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 0, 0, 0);
        send_pose(OP_ROT, 32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0);
        send_pose(OP_ROT, 32'h0100_0000, 0, 0, 0, 0, 32'h0324_3F6A, 0);
        send_pose(OP_ROT, 32'h0100_0000, 0, 0, 0, 0, 0, 32'h0192_1FB5);
        send_pose(OP_ROT, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000,
                  32'h0080_0000, 1, 0, 0);
        send_pose(OP_ROT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000);
        send_pose(OP_ROT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pose(OP_ROT, 32'h3000_0000, 32'hD000_0000, 32'h1000_0000,
                  32'hF000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pose(OP_ROT, 32'h0100_0000, 0, 0, 0, 32'hFF00_0000, 32'h0200_0000,
                  32'hFD00_0000);
        send_pose(OP_TRANS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'h8765_4321);
        send_pose(OP_TRANS, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_pose(OP_TRANS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pose(OP_TRANS, 0, 0, 0, 0, 0, 0, 0);

        // random phases: none, sender idle, receiver stall, both
        for (int i = 0; i < 1400; i++)
        begin
            case (i / 350)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            if (i == 700)
                drain();    // sender pauses until every result is back
            send_random();
        end
        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pqr_pkg.sv
hw/rtl/pose_quaternion_retraction.sv
hw/rtl/pqr_checker.sv
tb/pqr_checker.sv
tb/tb_top.sv
